// File: rtl/arct_pkg.sv
// shared types and constants of the allocation refcount table
`default_nettype none
package arct_pkg;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 3;
  localparam int ACT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_RESET   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_MARK    = 2'd3;

  localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW       = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_RESET     = 3'd4;

  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 32'hffff_ffff;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
  localparam logic signed [COUNT_W-1:0] COUNT_ONE = 16'sh0001;
  localparam logic signed [COUNT_W-1:0] COUNT_NEG = 16'shffff;

  // one table entry as stored
  typedef struct packed {
    logic [ADDR_W-1:0]         blk_start;
    logic [ADDR_W-1:0]         blk_end;
    logic signed [COUNT_W-1:0] count;
  } entry_t;

  // event handed to the table
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] blk_start;
    logic [ADDR_W-1:0] blk_end;
  } req_t;

  // table outcome of one event
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic [INDEX_W-1:0]        index;
    logic signed [COUNT_W-1:0] count;
  } rsp_t;

endpackage
`default_nettype wire

// File: rtl/arct_if.sv
// valid/ready channel interfaces for events and results
`default_nettype none
interface arct_in_if;
  logic                            valid;
  logic                            ready;
  logic [arct_pkg::ACT_W-1:0]      action;
  logic [arct_pkg::ADDR_W-1:0]     block_address;
  logic [arct_pkg::ADDR_W-1:0]     block_size;

  modport source (output valid, action, block_address, block_size, input ready);
  modport sink (input valid, action, block_address, block_size, output ready);
endinterface

interface arct_out_if;
  logic                                valid;
  logic                                ready;
  logic [arct_pkg::STAT_W-1:0]         status;
  logic [arct_pkg::INDEX_W-1:0]        entry_index;
  logic signed [arct_pkg::COUNT_W-1:0] ref_count;
  logic [arct_pkg::ADDR_W-1:0]         span_low;
  logic [arct_pkg::ADDR_W-1:0]         span_high;
  logic [arct_pkg::ADDR_W-1:0]         span_size;

  modport source (output valid, status, entry_index, ref_count, span_low, span_high,
                  span_size, input ready);
  modport sink (input valid, status, entry_index, ref_count, span_low, span_high,
                span_size, output ready);
endinterface
`default_nettype wire

// File: rtl/arct_table.sv
// entry memory with sequential match scan and read-modify-write of counts
`default_nettype none
module arct_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire arct_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output arct_pkg::rsp_t     rsp
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  arct_pkg::entry_t mem [TABLE_DEPTH];
  arct_pkg::entry_t rd_data_r;

  logic [1:0]        state_r, state_nxt;
  arct_pkg::req_t    req_r, req_nxt;
  arct_pkg::rsp_t    rsp_r, rsp_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;

  logic              re;
  logic              we;
  logic [IW-1:0]     wa;
  arct_pkg::entry_t  wd;
  logic              match;
  logic              full;
  logic signed [arct_pkg::COUNT_W-1:0] new_count;

  assign full  = (used_r == CW'(TABLE_DEPTH));
  assign match = pend_r && (rd_data_r.blk_start == req_r.blk_start)
                 && (rd_data_r.blk_end == req_r.blk_end);

  // saturating count update of the matched entry
  always_comb begin
    new_count = rd_data_r.count;
    if (req_r.action == arct_pkg::ACT_ALLOC) begin
      if (rd_data_r.count != arct_pkg::COUNT_MAX) new_count = rd_data_r.count + arct_pkg::COUNT_ONE;
    end else begin
      if (rd_data_r.count != arct_pkg::COUNT_MIN) new_count = rd_data_r.count - arct_pkg::COUNT_ONE;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    rsp_nxt     = rsp_r;
    used_nxt    = used_r;
    rd_idx_nxt  = rd_idx_r;
    pend_nxt    = pend_r;
    cmp_idx_nxt = cmp_idx_r;
    re          = 1'b0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          case (req.action)
            arct_pkg::ACT_RESET: begin
              used_nxt  = '0;
              rsp_nxt   = '{status: arct_pkg::ST_RESET, index: '0, count: '0};
              state_nxt = S_DONE;
            end
            arct_pkg::ACT_MARK: begin
              if (full) begin
                rsp_nxt = '{status: arct_pkg::ST_FULL, index: '0, count: '0};
              end else begin
                we       = 1'b1;
                wa       = used_r[IW-1:0];
                wd       = '{blk_start: req.blk_start, blk_end: req.blk_end,
                             count: arct_pkg::COUNT_NEG};
                used_nxt = used_r + CW'(1);
                rsp_nxt  = '{status: arct_pkg::ST_NEW,
                             index: arct_pkg::INDEX_W'(used_r[IW-1:0]),
                             count: arct_pkg::COUNT_NEG};
              end
              state_nxt = S_DONE;
            end
            default: begin
              rd_idx_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          we        = 1'b1;
          wa        = cmp_idx_r;
          wd        = '{blk_start: req_r.blk_start, blk_end: req_r.blk_end, count: new_count};
          rsp_nxt   = '{status: arct_pkg::ST_UPDATED,
                        index: arct_pkg::INDEX_W'(cmp_idx_r), count: new_count};
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (!pend_r && (rd_idx_r == used_r)) begin
          // scan exhausted without a hit
          if (req_r.action == arct_pkg::ACT_ALLOC) begin
            if (full) begin
              rsp_nxt = '{status: arct_pkg::ST_FULL, index: '0, count: '0};
            end else begin
              we       = 1'b1;
              wa       = used_r[IW-1:0];
              wd       = '{blk_start: req_r.blk_start, blk_end: req_r.blk_end,
                           count: arct_pkg::COUNT_ONE};
              used_nxt = used_r + CW'(1);
              rsp_nxt  = '{status: arct_pkg::ST_NEW,
                           index: arct_pkg::INDEX_W'(used_r[IW-1:0]),
                           count: arct_pkg::COUNT_ONE};
            end
          end else begin
            rsp_nxt = '{status: arct_pkg::ST_NOT_FOUND, index: '0, count: '0};
          end
          state_nxt = S_DONE;
        end else if (rd_idx_r < used_r) begin
          // read one entry a cycle, compare it the cycle after
          re          = 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (rsp_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[rd_idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rsp_r     <= rsp_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);
  assign rsp       = rsp_r;

endmodule
`default_nettype wire

// File: rtl/allocation_refcount_table.sv
// Allocation refcount table: tracks memory blocks by start and end address with a signed
// reference count per block, plus the address span seen since the last reset event. One
// event is worked on at a time and gives one result. A reset or mark-removed result goes
// from the idle state into the table's result register and then into the output register.
// Allocate and release scan the stored entries through the single read port of the entry
// memory, one entry per cycle, each read registered and compared in the cycle after it: a
// hit ends the scan, a miss ends it once every used entry has been read. A new event is
// taken in the cycle after the previous result has moved into the output register, even if
// that result is not yet taken. The entry memory needs no clearing pass: only entries below
// the fill count are read.
`default_nettype none
module allocation_refcount_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  arct_in_if.sink   in_ch,
  arct_out_if.source out_ch
);

  logic                          req_ready;
  arct_pkg::req_t                req;
  logic                          rsp_valid;
  logic                          rsp_ready;
  arct_pkg::rsp_t                rsp;
  logic                          in_xfer;
  logic                          rsp_xfer;

  logic [arct_pkg::ADDR_W-1:0]   low_r, low_nxt;
  logic [arct_pkg::ADDR_W-1:0]   high_r, high_nxt;
  logic [arct_pkg::ADDR_W-1:0]   blk_end;
  logic                          out_valid_r, out_valid_nxt;

  arct_pkg::rsp_t                out_rsp_r;
  logic [arct_pkg::ADDR_W-1:0]   out_low_r, out_high_r, out_size_r;

  assign blk_end = in_ch.block_address + in_ch.block_size - arct_pkg::ADDR_W'(1);
  assign req     = '{action: in_ch.action, blk_start: in_ch.block_address, blk_end: blk_end};

  assign in_ch.ready = req_ready;
  assign in_xfer     = in_ch.valid && req_ready;
  assign rsp_ready   = !out_valid_r || out_ch.ready;
  assign rsp_xfer    = rsp_valid && rsp_ready;

  arct_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_xfer),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // span widens on every event but reset
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (in_xfer) begin
      if (in_ch.action == arct_pkg::ACT_RESET) begin
        low_nxt  = arct_pkg::ADDR_ALL_ONES;
        high_nxt = '0;
      end else begin
        if (in_ch.block_address < low_r) low_nxt = in_ch.block_address;
        if (blk_end > high_r) high_nxt = blk_end;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (rsp_xfer) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= arct_pkg::ADDR_ALL_ONES;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // span registers already hold this event's values when its result is ready
  always_ff @(posedge clk) begin
    if (rsp_xfer) begin
      out_rsp_r  <= rsp;
      out_low_r  <= low_r;
      out_high_r <= high_r;
      out_size_r <= (rsp.status == arct_pkg::ST_RESET) ? '0 : (high_r - low_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_rsp_r.status;
  assign out_ch.entry_index = out_rsp_r.index;
  assign out_ch.ref_count   = out_rsp_r.count;
  assign out_ch.span_low    = out_low_r;
  assign out_ch.span_high   = out_high_r;
  assign out_ch.span_size   = out_size_r;

endmodule
`default_nettype wire
